>>> sv/blbpe_pkg.sv
// Shared types, constants and the inverse byte-to-unicode lookup
// for the byte-level BPE piece decoder. No dependencies.
`default_nettype none

package blbpe_pkg;

	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned CpWidth           = 21;

	// Decoded work for one accepted word, passed from front to back.
	typedef struct packed {
		logic            last;
		logic            has_data;
		logic            mapped;
		logic [7:0]      mbyte;
		logic [1:0]      cnt;
		logic [3:0][7:0] seq;
	} job_t;

	// One result word as it leaves the block.
	typedef struct packed {
		logic       piece_end;
		logic       run_last;
		logic       has_byte;
		logic [7:0] out_byte;
	} res_t;

	// Returns {hit, byte}.
	function automatic logic [8:0] inv_lookup(input logic [CpWidth-1:0] cp);
		logic [8:0] r;
		logic [8:0] low9;
		logic [8:0] diff;
		low9 = cp[8:0];
		diff = low9 - 9'd162;
		r = 9'd0;
		if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
				(cp >= 21'd174 && cp <= 21'd255)) begin
			r = {1'b1, cp[7:0]};
		end else if (cp >= 21'd256 && cp <= 21'd288) begin
			r = {1'b1, cp[7:0]};
		end else if (cp == 21'd289) begin
			r = {1'b1, 8'd127};
		end else if (cp >= 21'd290 && cp <= 21'd322) begin
			r = {1'b1, diff[7:0]};
		end else if (cp == 21'd323) begin
			r = {1'b1, 8'd173};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/blbpe_front.sv
// Front end: accepts input words, assembles UTF-8 sequences and builds jobs.
// Depends on blbpe_pkg.
`default_nettype none

module blbpe_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire [7:0]           in_byte,
	input  wire                 piece_last,
	input  wire                 q_full,
	output logic                in_ready,
	output logic                push,
	output blbpe_pkg::job_t     job
);

	logic [1:0]                      exp_q;
	logic [1:0]                      held_cnt_q;
	logic [2:0][7:0]                 held_q;
	logic [blbpe_pkg::CpWidth-1:0]   part_q;

	logic [1:0]                      n_exp;
	logic [1:0]                      n_cnt;
	logic [2:0][7:0]                 n_held;
	logic [blbpe_pkg::CpWidth-1:0]   n_part;
	logic [blbpe_pkg::CpWidth-1:0]   acc;
	logic [blbpe_pkg::CpWidth-1:0]   cp;
	logic [8:0]                      lk;
	logic                            done;
	logic                            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		acc    = {part_q[14:0], in_byte[5:0]};
		n_exp  = exp_q;
		n_cnt  = held_cnt_q;
		n_held = held_q;
		n_part = part_q;
		done   = 1'b0;
		cp     = '0;
		job    = '0;
		if (exp_q == 2'd0) begin
			if (!in_byte[7]) begin
				done       = 1'b1;
				cp         = {13'd0, in_byte};
				job.seq[0] = in_byte;
				job.cnt    = 2'd0;
			end else if (in_byte[7:5] == 3'b110) begin
				n_part    = {16'd0, in_byte[4:0]};
				n_exp     = 2'd1;
				n_held[0] = in_byte;
				n_cnt     = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				n_part    = {17'd0, in_byte[3:0]};
				n_exp     = 2'd2;
				n_held[0] = in_byte;
				n_cnt     = 2'd1;
			end else if (in_byte[7:3] == 5'b11110) begin
				n_part    = {18'd0, in_byte[2:0]};
				n_exp     = 2'd3;
				n_held[0] = in_byte;
				n_cnt     = 2'd1;
			end
		end else if (exp_q == 2'd1) begin
			done                 = 1'b1;
			cp                   = acc;
			job.seq              = {8'd0, held_q};
			job.seq[held_cnt_q]  = in_byte;
			job.cnt              = held_cnt_q;
			n_exp                = 2'd0;
			n_cnt                = 2'd0;
			n_part               = '0;
		end else begin
			if (held_cnt_q != 2'd3) begin
				n_held[held_cnt_q] = in_byte;
				n_cnt              = held_cnt_q + 2'd1;
			end
			n_part = acc;
			n_exp  = exp_q - 2'd1;
		end
		lk           = blbpe_pkg::inv_lookup(cp);
		job.mapped   = lk[8];
		job.mbyte    = lk[7:0];
		job.has_data = done;
		job.last     = piece_last;
		if (piece_last) begin
			n_exp  = 2'd0;
			n_cnt  = 2'd0;
			n_part = '0;
		end
	end

	assign push = accept && (done || piece_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q      <= 2'd0;
			held_cnt_q <= 2'd0;
			part_q     <= '0;
		end else if (accept) begin
			exp_q      <= n_exp;
			held_cnt_q <= n_cnt;
			part_q     <= n_part;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= n_held;
		end
	end

endmodule

`default_nettype wire

>>> sv/blbpe_queue.sv
// Short job queue between front and back ends.
// Depends on blbpe_pkg.
`default_nettype none

module blbpe_queue #(
	parameter int unsigned DEPTH = blbpe_pkg::QueueDepthDefault
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  blbpe_pkg::job_t              wr_job,
	input  wire                          pop,
	output blbpe_pkg::job_t              rd_job,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LW = $clog2(DEPTH+1);

	blbpe_pkg::job_t    mem_q [DEPTH];
	logic [AW-1:0]      wptr_q;
	logic [AW-1:0]      rptr_q;
	logic [LW-1:0]      cnt_q;
	logic               do_push;
	logic               do_pop;

	assign empty   = (cnt_q == LW'(0));
	assign full    = (cnt_q == LW'(DEPTH));
	assign level   = cnt_q;
	assign rd_job  = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

>>> sv/blbpe_back.sv
// Back end: expands queued jobs into result words through an output register.
// Depends on blbpe_pkg.
`default_nettype none

module blbpe_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  blbpe_pkg::job_t     job,
	input  wire                 q_empty,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output blbpe_pkg::res_t     res
);

	logic [1:0]        idx_q;
	logic              ovalid_q;
	blbpe_pkg::res_t   res_q;
	blbpe_pkg::res_t   nxt;
	logic              load;
	logic              last_elem;

	assign load = !q_empty && (!ovalid_q || out_ready);

	always_comb begin
		last_elem = !job.has_data || job.mapped || (idx_q == job.cnt);
		nxt       = '0;
		if (!job.has_data) begin
			nxt.out_byte = 8'd0;
			nxt.has_byte = 1'b0;
		end else if (job.mapped) begin
			nxt.out_byte = job.mbyte;
			nxt.has_byte = 1'b1;
		end else begin
			nxt.out_byte = job.seq[idx_q];
			nxt.has_byte = 1'b1;
		end
		nxt.run_last  = last_elem;
		nxt.piece_end = last_elem && job.last;
	end

	assign pop = load && last_elem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q    <= last_elem ? 2'd0 : idx_q + 2'd1;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= nxt;
		end
	end

	assign out_valid = ovalid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> sv/byte_level_bpe_decoder.sv
// Top level of the byte-level BPE piece decoder: front, job queue, back.
// Depends on blbpe_pkg, blbpe_front, blbpe_queue and blbpe_back.
`default_nettype none

// Takes UTF-8 bytes of token pieces one word per cycle and returns the original
// bytes, mapping code points 33..126, 161..172 and 174..323 back through the
// inverse byte-to-unicode table and passing unmapped sequences through raw. Each
// input word is decoded in the cycle it is accepted; one that ends a sequence or
// a piece leaves a job in a queue of DEPTH entries. The back end emits one result
// word per cycle, while not stalled, from the output register, one to four words
// per job. Input is accepted every cycle while the queue has room; a piece_last
// word with no data yields one bare end word with has_byte low.
module byte_level_bpe_decoder #(
	parameter int unsigned DEPTH = blbpe_pkg::QueueDepthDefault
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire        s_axis_tlast,   // piece_last
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] run_last
	output logic       m_axis_tlast    // piece_end
);

	blbpe_pkg::job_t                wr_job;
	blbpe_pkg::job_t                rd_job;
	blbpe_pkg::res_t                res;
	logic                           push;
	logic                           pop;
	logic                           q_empty;
	logic                           q_full;
	logic [$clog2(DEPTH+1)-1:0]     q_level;

	blbpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.piece_last (s_axis_tlast),
		.q_full     (q_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.job        (wr_job)
	);

	blbpe_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (q_empty),
		.full   (q_full),
		.level  (q_level)
	);

	blbpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = res.out_byte;
	assign m_axis_tuser = {res.run_last, res.has_byte};
	assign m_axis_tlast = res.piece_end;

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("piece end without run end");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast)
		else $error("bare word is not a clean end marker");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(DEPTH+1))'(DEPTH) && (s_axis_tready == !q_full))
		else $error("queue level out of range");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for byte_level_bpe_decoder: streams UTF-8 token pieces into the block and
// checks every output word against an in-bench decoder of the inverse byte mapping.
// Depends on blbpe_pkg (result word type) and the decoder RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned RandomItems = 450;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	byte_level_bpe_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// decoder state mirrored in the bench
	logic [1:0]  owed = 2'd0;
	logic [1:0]  nheld = 2'd0;
	logic [7:0]  held [3] = '{8'd0, 8'd0, 8'd0};
	logic [20:0] cp_acc = 21'd0;

	blbpe_pkg::res_t decoded_q [$];
	int unsigned mismatches = 0;
	int unsigned word_count = 0;
	int unsigned live_items = 0;
	int unsigned burst_left = 0;
	int unsigned cycles = 0;
	logic [15:0] rdy_pat = 16'hffff;
	logic [5:0]  rdy_cnt = 6'd0;

	// {hit, byte} of the inverse byte-to-unicode table
	function automatic logic [8:0] unmap_cp(input logic [20:0] cp);
		int unsigned v;
		v = cp;
		if ((v >= 33 && v <= 126) || (v >= 161 && v <= 172) || (v >= 174 && v <= 255))
			return {1'b1, cp[7:0]};
		if (v >= 256 && v <= 288)
			return {1'b1, 8'(v - 256)};
		if (v == 289)
			return {1'b1, 8'd127};
		if (v >= 290 && v <= 322)
			return {1'b1, 8'(v - 162)};
		if (v == 323)
			return {1'b1, 8'd173};
		return 9'd0;
	endfunction

	function automatic void drop_seq();
		owed = 2'd0;
		nheld = 2'd0;
		cp_acc = 21'd0;
		held = '{8'd0, 8'd0, 8'd0};
	endfunction

	// Advance the mirrored decoder by one word and queue the words it yields.
	// Returns 1 when the word is dropped without effect.
	function automatic bit decode_word(input logic [7:0] b, input logic l);
		logic [7:0]  seq [4];
		int unsigned slen;
		logic        done;
		logic [20:0] cp;
		logic [20:0] acc;
		logic [8:0]  hit;
		blbpe_pkg::res_t outs [4];
		int unsigned n;
		bit          ignored;
		slen = 0;
		done = 1'b0;
		cp = 21'd0;
		n = 0;
		ignored = 1'b0;
		if (owed == 2'd0) begin
			if (!b[7]) begin
				cp = {13'd0, b};
				seq[0] = b;
				slen = 1;
				done = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				cp_acc = {16'd0, b[4:0]};
				owed = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc = {17'd0, b[3:0]};
				owed = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc = {18'd0, b[2:0]};
				owed = 2'd3;
			end else begin
				ignored = !l;
			end
			if (owed != 2'd0) begin
				held[0] = b;
				nheld = 2'd1;
			end
		end else begin
			acc = {cp_acc[14:0], b[5:0]};
			if (owed == 2'd1) begin
				for (int i = 0; i < nheld; i++)
					seq[i] = held[i];
				seq[nheld] = b;
				slen = nheld + 1;
				cp = acc;
				done = 1'b1;
				drop_seq();
			end else begin
				if (nheld < 2'd3) begin
					held[nheld] = b;
					nheld = nheld + 2'd1;
				end
				cp_acc = acc;
				owed = owed - 2'd1;
			end
		end
		if (done) begin
			hit = unmap_cp(cp);
			if (hit[8]) begin
				outs[n] = '{piece_end: 1'b0, run_last: 1'b0, has_byte: 1'b1, out_byte: hit[7:0]};
				n++;
			end else begin
				for (int i = 0; i < slen; i++) begin
					outs[n] = '{piece_end: 1'b0, run_last: 1'b0, has_byte: 1'b1, out_byte: seq[i]};
					n++;
				end
			end
		end
		if (l) begin
			drop_seq();
			if (n == 0) begin
				outs[0] = '{piece_end: 1'b0, run_last: 1'b0, has_byte: 1'b0, out_byte: 8'd0};
				n = 1;
			end
			outs[n-1].piece_end = 1'b1;
		end
		if (n > 0)
			outs[n-1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			decoded_q.push_back(outs[i]);
		return ignored;
	endfunction

	// Called just after a rising edge; returns just after the edge that takes the word.
	task automatic send_word(input logic [7:0] b, input logic l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (!decode_word(b, l))
			live_items++;
	endtask

	// Send code point cp in an n-byte UTF-8 form, cut after keep bytes.
	task automatic send_seq(input logic [20:0] cp, input int n, input int keep, input bit l);
		logic [7:0] bs [4];
		case (n)
			1: bs[0] = {1'b0, cp[6:0]};
			2: begin
				bs[0] = {3'b110, cp[10:6]};
				bs[1] = {2'b10, cp[5:0]};
			end
			3: begin
				bs[0] = {4'b1110, cp[15:12]};
				bs[1] = {2'b10, cp[11:6]};
				bs[2] = {2'b10, cp[5:0]};
			end
			default: begin
				bs[0] = {5'b11110, cp[20:18]};
				bs[1] = {2'b10, cp[17:12]};
				bs[2] = {2'b10, cp[11:6]};
				bs[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int k = 0; k < keep; k++)
			send_word(bs[k], l && (k == keep - 1));
	endtask

	task automatic test_single_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'h21, 1'b0);
		send_word(8'h7f, 1'b1);
	endtask

	task automatic test_multibyte_forms();
		send_seq(21'h100, 2, 2, 1'b0);
		send_seq(21'h121, 2, 2, 1'b0);
		send_seq(21'h143, 2, 2, 1'b0);
		send_seq(21'h400, 2, 2, 1'b1);
		send_seq(21'h20ac, 3, 3, 1'b0);
		send_seq(21'h10ffff, 4, 4, 1'b1);
	endtask

	task automatic test_malformed_input();
		send_seq(21'h21, 2, 2, 1'b0);
		send_word(8'hc4, 1'b0);
		send_word(8'h41, 1'b1);
		send_word(8'h80, 1'b0);
		send_word(8'hf8, 1'b0);
		send_word(8'hff, 1'b1);
		send_seq(21'h20ac, 3, 2, 1'b1);
	endtask

	task automatic test_random_pieces();
		int unsigned plen;
		int unsigned r;
		int unsigned n;
		int unsigned lead;
		bit          l;
		while (live_items < RandomItems) begin
			plen = $urandom_range(1, 6);
			for (int j = 0; j < plen; j++) begin
				l = (j == plen - 1);
				r = $urandom_range(0, 99);
				if (r < 40) begin
					r = $urandom_range(33, 323);
					n = (r < 128) ? 1 : 2;
					if ($urandom_range(0, 4) == 0)
						n = $urandom_range(n, 4);
					send_seq(21'(r), n, n, l);
				end else if (r < 55) begin
					send_word(8'($urandom_range(0, 127)), l);
				end else if (r < 70) begin
					n = $urandom_range(2, 4);
					send_seq(21'($urandom), n, n, l);
				end else if (r < 80) begin
					lead = $urandom_range(8'hc0, 8'hf7);
					n = (lead >= 8'hf0) ? 3 : (lead >= 8'he0) ? 2 : 1;
					send_word(8'(lead), 1'b0);
					for (int k = 0; k < n; k++)
						send_word(8'($urandom), l && (k == n - 1));
				end else if (r < 90) begin
					n = $urandom_range(2, 4);
					send_seq(21'($urandom), n, $urandom_range(1, n - 1), 1'b1);
					break;
				end else begin
					if ($urandom_range(0, 1) == 0)
						send_word(8'($urandom_range(8'h80, 8'hbf)), l);
					else
						send_word(8'($urandom_range(8'hf8, 8'hff)), l);
				end
			end
		end
	endtask

	// check each accepted output word, then step the stall pattern
	always @(posedge clk) begin
		blbpe_pkg::res_t want;
		blbpe_pkg::res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{piece_end: m_axis_tlast, run_last: m_axis_tuser[1],
				has_byte: m_axis_tuser[0], out_byte: m_axis_tdata};
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d: unexpected, got byte %h has %b run_last %b end %b",
						word_count, got.out_byte, got.has_byte, got.run_last, got.piece_end);
			end else begin
				want = decoded_q.pop_front();
				if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
						got.run_last !== want.run_last || got.piece_end !== want.piece_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"word %0d: expected byte %h has %b run_last %b end %b, ",
							"got byte %h has %b run_last %b end %b"}, word_count,
							want.out_byte, want.has_byte, want.run_last, want.piece_end,
							got.out_byte, got.has_byte, got.run_last, got.piece_end);
				end
			end
			word_count++;
		end
		if (rdy_cnt == 6'd0) begin
			case ($urandom_range(0, 3))
				0: rdy_pat = 16'hffff;
				1: rdy_pat = 16'($urandom) | 16'h0001;
				2: rdy_pat = 16'h0101;
				default: rdy_pat = 16'($urandom) | 16'h8000;
			endcase
		end
		rdy_cnt <= rdy_cnt + 6'd1;
		m_axis_tready <= rdy_pat[rdy_cnt[3:0]];
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		test_multibyte_forms();
		test_malformed_input();
		test_random_pieces();
		s_axis_tvalid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
